// File: rtl/vmph_pkg.sv
// ============================================================================
// VU meter package
// Shared widths, codes, structs and helpers for the stereo VU meter.
// ============================================================================
package vmph_pkg;

    localparam int LEVEL_MAX_DEF     = 32767;
    localparam int SMOOTH_FACTOR_DEF = 4;

    localparam int IN_W   = 15;
    localparam int LVL_W  = 16;
    localparam int CD_W   = 18;
    localparam int LPL_W  = 22;
    localparam int TICK_W = 16;
    localparam int SW_W   = 9;
    localparam int YS_W   = 16;
    localparam int LED_W  = 8;
    localparam int COL_W  = 2;

    localparam int NUM_W = 24;
    localparam int DEN_W = 22;
    localparam int CNT_W = $clog2(LED_W + 1);

    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    localparam logic [LED_W-1:0] LED_SAT = {LED_W{1'b1}};

    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;
    localparam logic [LVL_W-1:0] DROP_STEP_DEF = 16'd1365;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LPL    = 3'd0,
        CFG_HOLD   = 3'd1,
        CFG_DROP   = 3'd2,
        CFG_STEP   = 3'd3,
        CFG_YSTART = 3'd4
    } t_cfg_idx;

    typedef enum logic [COL_W-1:0] {
        COL_GREEN  = 2'd0,
        COL_YELLOW = 2'd1,
        COL_RED    = 2'd2
    } t_color;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_LOAD,
        ST_SMOOTH,
        ST_WB,
        ST_DIV_B,
        ST_DIV_P,
        ST_RPT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [LVL_W-1:0] sm;
        logic [LVL_W-1:0] pk;
        logic [CD_W-1:0]  cd;
    } t_chan_st;

    typedef struct packed {
        logic [LED_W-1:0] bar;
        logic [LED_W-1:0] pos;
        logic [COL_W-1:0] color;
        logic             over;
    } t_chan_res;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    function automatic logic [NUM_W-1:0] led_num(input logic [LVL_W-1:0] level,
                                                 input logic [LPL_W-1:0] span);
        led_num = NUM_W'(level) * NUM_W'(100) + NUM_W'(span) - NUM_W'(1);
    endfunction

    function automatic logic led_sat(input logic [NUM_W-1:0] num,
                                     input logic [LPL_W-1:0] span);
        led_sat = (LPL_W + LED_W)'(num) >= {span, {LED_W{1'b0}}};
    endfunction

endpackage

// File: rtl/vmph_ram.sv
// ============================================================================
// Generic RAM
// Single write port, single read port, registered read data.
// ============================================================================
module vmph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/vmph_div.sv
// ============================================================================
// Serial divider
// Restoring division, one quotient bit per cycle, 8 quotient bits.
// ============================================================================
module vmph_div import vmph_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_busy,
    output logic             o_done,
    output logic [LED_W-1:0] o_quo
);

    logic [DEN_W:0]   r_rem, n_rem;
    logic [NUM_W-1:0] r_num, n_num;
    logic [LED_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DEN_W+1:0] cand;
    logic             fits;

    always_comb begin
        n_rem  = r_rem;
        n_num  = r_num;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        cand   = {r_rem, r_num[NUM_W-1]};
        fits   = cand >= (DEN_W + 2)'(r_den);
        if (i_req.start) begin
            n_den  = i_req.den;
            n_quo  = '0;
            n_busy = 1'b1;
            n_rem  = (DEN_W + 1)'(i_req.num >> LED_W);
            n_num  = i_req.num << (NUM_W - LED_W);
            n_cnt  = CNT_W'(LED_W);
        end else if (r_busy) begin
            n_rem = fits ? (DEN_W + 1)'(cand - (DEN_W + 2)'(r_den)) : cand[DEN_W:0];
            n_num = r_num << 1;
            n_quo = {r_quo[LED_W-2:0], fits};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_num <= n_num;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/vu_meter_peak_hold.sv
// ============================================================================
// Stereo VU meter with peak hold
// Smoothed bar level, held peak with timed drop, LED counts and peak colour.
// ============================================================================
// Sequence: each channel in turn is read, loaded, smoothed, written back, divided
// for bar and peak and reported, then the result goes out; a request is taken in idle only;
// four serial 8-bit LED-count divisions per request on one divider, smoothing
// by reciprocal multiply. A new request is taken while the previous result still waits.
// Reset: synchronous; registers take their defaults, channel state reads zero.
// ============================================================================
module vu_meter_peak_hold import vmph_pkg::*; #(
    parameter int LEVEL_MAX     = LEVEL_MAX_DEF,
    parameter int SMOOTH_FACTOR = SMOOTH_FACTOR_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [14:0] left_level, [29:15] right_level
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [7:0] left_bar_leds, [15:8] left_peak_led, [17:16] left_peak_color,
    // [18] left_over_range, [26:19] right_bar_leds, [34:27] right_peak_led,
    // [36:35] right_peak_color, [37] right_over_range
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LPL_W-1:0]     i_cfg_data
);

    localparam int CH_N = 2;
    localparam logic [LVL_W-1:0] LVL_MAX_V = LVL_W'(LEVEL_MAX);
    localparam int SNUM_W    = IN_W + 6;
    localparam int SM_SHIFT  = SNUM_W + 6;
    localparam int SM_PROD_W = SNUM_W + SM_SHIFT;
    localparam logic [SNUM_W-1:0]   SF_M1     = SNUM_W'(SMOOTH_FACTOR - 1);
    localparam logic [SNUM_W-1:0]   SF_HALF   = SNUM_W'(SMOOTH_FACTOR / 2);
    localparam logic [SM_SHIFT-1:0] SF_RECIP  =
        SM_SHIFT'(((1 << SM_SHIFT) + SMOOTH_FACTOR - 1) / SMOOTH_FACTOR);
    localparam int PROD_W = LPL_W + RECIP_W;
    localparam int X_W    = SW_W + LED_W;

    logic [LPL_W-1:0]  r_lpl;
    logic [TICK_W-1:0] r_hold, r_drop;
    logic [SW_W-1:0]   r_step;
    logic [YS_W-1:0]   r_ystart;
    logic [LVL_W-1:0]  r_drop_step;
    logic [PROD_W-1:0] drop_prod;
    logic [LPL_W-1:0]  span;

    t_state           r_state, n_state;
    logic             r_ch, n_ch;
    logic [IN_W-1:0]  r_lvl_in [CH_N];
    logic [IN_W-1:0]  n_lvl_in [CH_N];
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic             r_take, n_take;
    logic [SNUM_W-1:0] r_snum, n_snum;
    logic [LVL_W-1:0] r_sm, n_sm;
    logic [LVL_W-1:0] r_pk, n_pk;
    logic [CD_W-1:0]  r_cd, n_cd;
    logic             r_sat, n_sat;
    logic [LED_W-1:0] r_bar, n_bar;
    logic [LED_W-1:0] r_pk_leds, n_pk_leds;
    t_chan_res        r_res [CH_N];
    t_chan_res        n_res [CH_N];
    logic [CH_N-1:0]  r_valid, n_valid;
    logic             r_m_valid, n_m_valid;
    logic [M_TDATA_W-1:0] r_m_tdata, n_m_tdata;

    logic             s_acc;
    t_div_req         div_req;
    logic             div_busy, div_done;
    logic [LED_W-1:0] div_quo;
    logic             ram_we;
    t_chan_st         ram_wdata;
    logic [$bits(t_chan_st)-1:0] ram_q;
    t_chan_st         cur;
    logic [LVL_W-1:0] lvl_sat;
    logic [SM_PROD_W-1:0] sm_prod;
    logic [LVL_W-1:0] sm_quo;
    logic [NUM_W-1:0] bar_num, pk_num;
    logic [LED_W-1:0] led_val;
    logic [X_W-1:0]   pk_x;
    logic             over;

    vmph_ram #(
        .WIDTH ($bits(t_chan_st)),
        .DEPTH (CH_N)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ch),
        .i_wdata (ram_wdata),
        .i_raddr (r_ch),
        .o_rdata (ram_q)
    );

    vmph_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign span      = (r_lpl == '0) ? LPL_W'(1) : r_lpl;
    assign drop_prod = PROD_W'(r_lpl) * PROD_W'(RECIP_100);
    assign s_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign cur       = r_valid[r_ch] ? t_chan_st'(ram_q) : '0;
    assign lvl_sat   = (LVL_W'(r_lvl_in[r_ch]) > LVL_MAX_V) ? LVL_MAX_V
                                                            : LVL_W'(r_lvl_in[r_ch]);
    assign sm_prod   = SM_PROD_W'(r_snum) * SM_PROD_W'(SF_RECIP);
    assign sm_quo    = sm_prod[SM_SHIFT +: LVL_W];
    assign bar_num   = led_num(r_sm, span);
    assign pk_num    = led_num(r_pk, span);
    assign led_val   = r_sat ? LED_SAT : div_quo;
    assign pk_x      = X_W'(r_step) * X_W'(r_pk_leds - LED_W'(1));
    assign over      = r_pk >= LVL_MAX_V;
    assign ram_wdata = '{sm: r_sm, pk: r_pk, cd: r_cd};

    always_comb begin
        n_state   = r_state;
        n_ch      = r_ch;
        n_lvl_in  = r_lvl_in;
        n_lvl     = r_lvl;
        n_take    = r_take;
        n_snum    = r_snum;
        n_sm      = r_sm;
        n_pk      = r_pk;
        n_cd      = r_cd;
        n_sat     = r_sat;
        n_bar     = r_bar;
        n_pk_leds = r_pk_leds;
        n_res     = r_res;
        n_valid   = r_valid;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_m_tdata = r_m_tdata;
        div_req   = '0;
        ram_we    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_lvl_in[0] = i_s_axis_tdata[IN_W-1:0];
                    n_lvl_in[1] = i_s_axis_tdata[2*IN_W-1:IN_W];
                    n_ch        = 1'b0;
                    n_state     = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_lvl  = lvl_sat;
                n_take = lvl_sat > cur.sm;
                if (lvl_sat >= cur.pk) begin
                    n_pk = lvl_sat;
                    n_cd = CD_W'(r_hold);
                end else if (cur.cd <= CD_W'(1)) begin
                    n_cd = CD_W'(r_drop);
                    n_pk = (cur.pk > r_drop_step) ? cur.pk - r_drop_step : '0;
                end else begin
                    n_pk = cur.pk;
                    n_cd = cur.cd - CD_W'(1);
                end
                n_snum  = SNUM_W'(cur.sm) * SF_M1 + SNUM_W'(lvl_sat) + SF_HALF;
                n_state = ST_SMOOTH;
            end
            ST_SMOOTH: begin
                n_sm    = r_take ? r_lvl : sm_quo;
                n_state = ST_WB;
            end
            ST_WB: begin
                ram_we        = 1'b1;
                n_valid[r_ch] = 1'b1;
                div_req.start = 1'b1;
                div_req.num   = bar_num;
                div_req.den   = span;
                n_sat         = led_sat(bar_num, span);
                n_state       = ST_DIV_B;
            end
            ST_DIV_B: begin
                if (div_done) begin
                    n_bar         = led_val;
                    div_req.start = 1'b1;
                    div_req.num   = pk_num;
                    div_req.den   = span;
                    n_sat         = led_sat(pk_num, span);
                    n_state       = ST_DIV_P;
                end
            end
            ST_DIV_P: begin
                if (div_done) begin
                    n_pk_leds = led_val;
                    n_state   = ST_RPT;
                end
            end
            ST_RPT: begin
                n_res[r_ch].bar  = r_bar;
                n_res[r_ch].over = over;
                if (r_pk_leds > r_bar) begin
                    n_res[r_ch].pos = r_pk_leds;
                    if (pk_x < X_W'(r_ystart)) begin
                        n_res[r_ch].color = COL_GREEN;
                    end else begin
                        n_res[r_ch].color = over ? COL_RED : COL_YELLOW;
                    end
                end else begin
                    n_res[r_ch].pos   = '0;
                    n_res[r_ch].color = COL_GREEN;
                end
                if (r_ch) begin
                    n_state = ST_OUT;
                end else begin
                    n_ch    = 1'b1;
                    n_state = ST_RD;
                end
            end
            ST_OUT: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_tdata = {2'b00,
                                 r_res[1].over, r_res[1].color, r_res[1].pos, r_res[1].bar,
                                 r_res[0].over, r_res[0].color, r_res[0].pos, r_res[0].bar};
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= 1'b0;
            r_valid     <= '0;
            r_m_valid   <= 1'b0;
            r_lpl       <= LPL_W'(136533);
            r_hold      <= TICK_W'(22);
            r_drop      <= TICK_W'(4);
            r_step      <= SW_W'(5);
            r_ystart    <= YS_W'(120);
            r_drop_step <= DROP_STEP_DEF;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_valid     <= n_valid;
            r_m_valid   <= n_m_valid;
            r_drop_step <= drop_prod[RECIP_SHIFT +: LVL_W];
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_LPL:    r_lpl    <= i_cfg_data;
                    CFG_HOLD:   r_hold   <= i_cfg_data[TICK_W-1:0];
                    CFG_DROP:   r_drop   <= i_cfg_data[TICK_W-1:0];
                    CFG_STEP:   r_step   <= i_cfg_data[SW_W-1:0];
                    CFG_YSTART: r_ystart <= i_cfg_data[YS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_lvl_in  <= n_lvl_in;
        r_lvl     <= n_lvl;
        r_take    <= n_take;
        r_snum    <= n_snum;
        r_sm      <= n_sm;
        r_pk      <= n_pk;
        r_cd      <= n_cd;
        r_sat     <= n_sat;
        r_bar     <= n_bar;
        r_pk_leds <= n_pk_leds;
        r_res     <= n_res;
        r_m_tdata <= n_m_tdata;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_tdata;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

    a_state_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_wdata.pk <= LVL_MAX_V) && (ram_wdata.sm <= LVL_MAX_V))
        else $error("channel state written above level maximum");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_m_valid && !i_m_axis_tready) |=> (r_state == ST_OUT))
        else $error("result overwritten while still pending");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == ST_RD) && !r_ch)
        else $error("request accepted without starting the left channel");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Stereo VU meter testbench
// Drives level pairs over the input stream, writes the meter registers between
// phases and checks each result against fixed values or a cycle-free model of
// smoothing, peak hold, peak drop, LED counts and peak colour. A short scripted
// part covers the extremes and corner settings; random phases with bursts and
// decays follow, under varying idle and back-pressure patterns.
// ============================================================================
module tb_top import vmph_pkg::*; ();

    localparam int CH_W            = 2 * LED_W + COL_W + 1;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASES          = 8;
    localparam int HOLDOFF_CYCLES  = 2000;
    localparam int TAIL_CYCLES     = 100;
    localparam int CYCLE_LIMIT     = 1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(CFG_YSTART + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    typedef struct packed {
        t_chan_res rt;
        t_chan_res lf;
    } t_meter_res;

    typedef enum logic { ROW_LEVELS, ROW_WRITE } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [LPL_W-1:0]     data;
        logic [IN_W-1:0]      left;
        logic [IN_W-1:0]      right;
        logic                 typed;
        t_meter_res           res;
    } t_script_row;

    localparam t_chan_res  QUIET  = '{bar: '0, pos: '0, color: COL_GREEN, over: 1'b0};
    localparam t_chan_res  FULL   = '{bar: 8'd24, pos: '0, color: COL_GREEN, over: 1'b1};
    localparam t_meter_res NO_RES = '0;
    localparam logic [IN_W-1:0] LMAX = IN_W'(LEVEL_MAX_DEF);

    localparam int SCRIPT_LEN = 32;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{ROW_LEVELS, CFG_LPL, '0, '0, '0, 1'b1, '{rt: QUIET, lf: QUIET}},
        '{ROW_LEVELS, CFG_LPL, '0, LMAX, LMAX, 1'b1, '{rt: FULL, lf: FULL}},
        '{ROW_LEVELS, CFG_LPL, '0, '0, '0, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, '0, LMAX, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, 15'd1, 15'd16384, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, 15'd21845, 15'd10922, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, 15'd10922, 15'd21845, 1'b0, NO_RES},
        '{ROW_WRITE, CFG_HOLD, 22'd0, '0, '0, 1'b0, NO_RES},
        '{ROW_WRITE, CFG_DROP, 22'd0, '0, '0, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, '0, '0, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, '0, '0, 1'b0, NO_RES},
        '{ROW_WRITE, CFG_LPL, 22'd0, '0, '0, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, LMAX, 15'd3, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, 15'd2, '0, 1'b0, NO_RES},
        '{ROW_WRITE, CFG_LPL, 22'd50, '0, '0, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, '0, '0, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, '0, '0, 1'b0, NO_RES},
        '{ROW_WRITE, CFG_STEP, 22'd0, '0, '0, 1'b0, NO_RES},
        '{ROW_WRITE, CFG_YSTART, 22'd0, '0, '0, 1'b0, NO_RES},
        '{ROW_WRITE, CFG_LPL, 22'h3FFFFF, '0, '0, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, LMAX, LMAX, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, '0, '0, 1'b0, NO_RES},
        '{ROW_WRITE, CFG_SPARE_LO, 22'h3FFFFF, '0, '0, 1'b0, NO_RES},
        '{ROW_WRITE, CFG_SPARE_HI, 22'h2AAAAA, '0, '0, 1'b0, NO_RES},
        '{ROW_WRITE, CFG_HOLD, 22'h3FFFFF, '0, '0, 1'b0, NO_RES},
        '{ROW_WRITE, CFG_DROP, 22'h3F0003, '0, '0, 1'b0, NO_RES},
        '{ROW_WRITE, CFG_STEP, 22'h3FFFFF, '0, '0, 1'b0, NO_RES},
        '{ROW_WRITE, CFG_YSTART, 22'h3FFFFF, '0, '0, 1'b0, NO_RES},
        '{ROW_WRITE, CFG_LPL, 22'd136533, '0, '0, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, LMAX, '0, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, '0, LMAX, 1'b0, NO_RES},
        '{ROW_LEVELS, CFG_LPL, '0, 15'd16383, 15'd16383, 1'b0, NO_RES}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 lvl_valid = 1'b0;
    logic                 lvl_ready;
    logic [S_TDATA_W-1:0] lvl_data  = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    logic [M_TDATA_W-1:0] res_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_LPL;
    logic [LPL_W-1:0]     cfg_data  = '0;

    logic [LPL_W-1:0]  m_lpl    = 22'd136533;
    logic [TICK_W-1:0] m_hold   = 16'd22;
    logic [TICK_W-1:0] m_drop   = 16'd4;
    logic [SW_W-1:0]   m_step   = 9'd5;
    logic [YS_W-1:0]   m_ystart = 16'd120;
    logic [LVL_W-1:0]  m_smooth [2] = '{'0, '0};
    logic [LVL_W-1:0]  m_peak   [2] = '{'0, '0};
    logic [CD_W-1:0]   m_count  [2] = '{'0, '0};

    t_meter_res  pending_readings [$];
    int unsigned env_level [2] = '{0, 0};
    int          tx_idle_pct   = 0;
    int          rx_stall_pct  = 0;
    int          holdoff_seq   = 0;
    int          holdoff_seen  = 0;
    int          holdoff_left  = 0;
    int          fail_count    = 0;
    int          cycle_count   = 0;

    vu_meter_peak_hold i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (lvl_valid),
        .o_s_axis_tready (lvl_ready),
        .i_s_axis_tdata  (lvl_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [LED_W-1:0] leds_of(input logic [LVL_W-1:0] lvl);
        longint unsigned span, n;
        span = (m_lpl == '0) ? 64'd1 : 64'(m_lpl);
        n = (64'(lvl) * 64'd100 + span - 64'd1) / span;
        return (n > 64'(LED_SAT)) ? LED_SAT : LED_W'(n);
    endfunction

    function automatic t_chan_res chan_tick(input int ch, input logic [IN_W-1:0] level);
        int unsigned lv, sm, step, x;
        logic [LED_W-1:0] bar, pk_leds;
        t_chan_res r;
        lv = level;
        if (lv > LEVEL_MAX_DEF)
            lv = LEVEL_MAX_DEF;
        sm = m_smooth[ch];
        if (lv > sm)
            sm = lv;
        else
            sm = (sm * (SMOOTH_FACTOR_DEF - 1) + lv + SMOOTH_FACTOR_DEF / 2) / SMOOTH_FACTOR_DEF;
        m_smooth[ch] = LVL_W'(sm);
        if (lv >= m_peak[ch]) begin
            m_peak[ch]  = LVL_W'(lv);
            m_count[ch] = CD_W'(m_hold);
        end else if (m_count[ch] <= 1) begin
            step        = m_lpl / 100;
            m_count[ch] = CD_W'(m_drop);
            m_peak[ch]  = (m_peak[ch] > step) ? LVL_W'(m_peak[ch] - step) : '0;
        end else begin
            m_count[ch] = m_count[ch] - 1'b1;
        end
        bar     = leds_of(m_smooth[ch]);
        pk_leds = leds_of(m_peak[ch]);
        r       = '0;
        r.bar   = bar;
        r.over  = (m_peak[ch] >= LEVEL_MAX_DEF);
        if (pk_leds > bar) begin
            x       = int'(m_step) * (int'(pk_leds) - 1);
            r.pos   = pk_leds;
            r.color = (x < m_ystart) ? COL_GREEN : (r.over ? COL_RED : COL_YELLOW);
        end
        return r;
    endfunction

    function automatic t_meter_res meter_tick(input logic [IN_W-1:0] left, right);
        t_meter_res r;
        r.lf = chan_tick(0, left);
        r.rt = chan_tick(1, right);
        return r;
    endfunction

    function automatic t_chan_res unpack_side(input logic [CH_W-1:0] bits);
        t_chan_res r;
        r.bar   = bits[LED_W-1:0];
        r.pos   = bits[2*LED_W-1:LED_W];
        r.color = bits[2*LED_W+COL_W-1:2*LED_W];
        r.over  = bits[CH_W-1];
        return r;
    endfunction

    function automatic logic [IN_W-1:0] next_level(input int ch);
        int unsigned r, lvl;
        r = $urandom_range(99);
        if (r < 8)
            return IN_W'($urandom);
        if (r < 10)
            env_level[ch] = $urandom_range(8192, LEVEL_MAX_DEF);
        else if (r < 12)
            env_level[ch] = LEVEL_MAX_DEF;
        else if (r < 13)
            env_level[ch] = 0;
        else
            env_level[ch] = env_level[ch] - env_level[ch] / 8;
        lvl = env_level[ch] + $urandom_range(0, env_level[ch] / 16);
        return (lvl > LEVEL_MAX_DEF) ? LMAX : IN_W'(lvl);
    endfunction

    task automatic check_side(input string side, input t_chan_res want, input t_chan_res got);
        if (got.bar !== want.bar) begin
            $error("%s_bar_leds: expected %0d, got %0d", side, want.bar, got.bar);
            fail_count++;
        end
        if (got.pos !== want.pos) begin
            $error("%s_peak_led: expected %0d, got %0d", side, want.pos, got.pos);
            fail_count++;
        end
        if (got.color !== want.color) begin
            $error("%s_peak_color: expected %0d, got %0d", side, want.color, got.color);
            fail_count++;
        end
        if (got.over !== want.over) begin
            $error("%s_over_range: expected %0d, got %0d", side, want.over, got.over);
            fail_count++;
        end
    endtask

    task automatic offer_levels(input logic [IN_W-1:0] left, right,
                                input logic typed, input t_meter_res typed_res);
        t_meter_res pred;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            lvl_valid <= 1'b0;
            @(posedge clk);
        end
        lvl_valid <= 1'b1;
        lvl_data  <= S_TDATA_W'({right, left});
        do @(posedge clk); while (!lvl_ready);
        pred = meter_tick(left, right);
        pending_readings.push_back(typed ? typed_res : pred);
    endtask

    task automatic wait_drained();
        lvl_valid <= 1'b0;
        do @(posedge clk); while (pending_readings.size() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LPL_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_LPL:    m_lpl    = data;
            CFG_HOLD:   m_hold   = data[TICK_W-1:0];
            CFG_DROP:   m_drop   = data[TICK_W-1:0];
            CFG_STEP:   m_step   = data[SW_W-1:0];
            CFG_YSTART: m_ystart = data[YS_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input int unsigned lpl, hold, drop, step, ystart);
        cfg_write(CFG_LPL, LPL_W'(lpl));
        cfg_write(CFG_HOLD, LPL_W'(hold));
        cfg_write(CFG_DROP, LPL_W'(drop));
        cfg_write(CFG_STEP, LPL_W'(step));
        cfg_write(CFG_YSTART, LPL_W'(ystart));
    endtask

    always @(posedge clk) begin : result_monitor
        t_meter_res want;
        if (res_valid && res_ready) begin
            if (pending_readings.size() == 0) begin
                $error("result with no request outstanding: %h", res_data);
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                check_side("left", want.lf, unpack_side(res_data[CH_W-1:0]));
                check_side("right", want.rt, unpack_side(res_data[2*CH_W-1:CH_W]));
            end
        end
    end

    always @(posedge clk) begin
        if (holdoff_seq != holdoff_seen) begin
            holdoff_seen = holdoff_seq;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left != 0) begin
            holdoff_left--;
            res_ready <= 1'b0;
        end else begin
            res_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int unsigned lpl, hold, drop, step, ystart, span;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (SCRIPT[i]) begin
            if (SCRIPT[i].kind == ROW_WRITE) begin
                wait_drained();
                cfg_write(SCRIPT[i].idx, SCRIPT[i].data);
            end else begin
                offer_levels(SCRIPT[i].left, SCRIPT[i].right, SCRIPT[i].typed, SCRIPT[i].res);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            if (p == 3) begin
                apply_setting(1, 0, 0, 1, 0);
            end else if (p == 6) begin
                apply_setting(3276800, 65535, 65535, 510, 65535);
            end else begin
                lpl    = ($urandom_range(9) == 0) ? $urandom_range(1, 3276800)
                                                  : $urandom_range(12850, 400000);
                hold   = $urandom_range(0, 40);
                drop   = $urandom_range(0, 10);
                step   = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 510);
                span   = step * (3276700 / lpl + 1);
                ystart = $urandom_range(0, (span > 65535) ? 65535 : span);
                apply_setting(lpl, hold, drop, step, ystart);
            end
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
                default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
            endcase
            if (p == 4)
                holdoff_seq++;
            repeat (ITEMS_PER_PHASE)
                offer_levels(next_level(0), next_level(1), 1'b0, NO_RES);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_readings.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
